FILE: sv/btint_pkg.sv
// ----------------------------------------------------------------------------
// btint_pkg
// Shared types and defaults for the B+-tree internal node table.
// ----------------------------------------------------------------------------
`default_nettype none

package btint_pkg;

  localparam int unsigned DefMaxCells = 16;
  localparam int unsigned DefKeyBits  = 32;

  localparam int unsigned PageBits  = 32;
  localparam int unsigned OutIdxBits = 4;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_INIT   = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Write controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;    // take key and page from the lower neighbor
    logic key_we;   // write new key at the target index
    logic page_we;  // write new page at the target index
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/btree_internal_node_table_top.sv
// ----------------------------------------------------------------------------
// btree_internal_node_table_top
// One B+-tree internal node held in a chain of key/page cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// passes the hit vector and output registers to the result ports, marked by
// valid_o for exactly one cycle; the receiver cannot stall, so it must take
// every result in that cycle. In the accept cycle every cell compares its
// key against the search key (the child key for insert) in parallel and the
// hit vector is registered; in the following cycle (busy high) the first hit
// is encoded, the cell chain writes for insert or update, shifting cells one
// slot up where needed, init resets the count and right child, and the
// result is loaded into the output registers. No new transaction is taken
// while busy is high. Find returns the first index whose key is not below
// the search key (the key count if none) and the page of that child, the
// right child standing at the key count. An insert into a full node is
// refused with status set and leaves the node unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module btree_internal_node_table_top #(
  parameter int unsigned MAX_CELLS = btint_pkg::DefMaxCells,
  parameter int unsigned KEY_BITS  = btint_pkg::DefKeyBits
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start,
  output logic                                   busy,
  input  wire  [1:0]                             mode_i,
  input  wire  [31:0]                            search_key_i,
  input  wire  [btint_pkg::PageBits-1:0]         child_page_i,
  input  wire  [31:0]                            child_key_i,
  input  wire                                    rightmost_i,
  output logic                                   valid_o,
  output logic [btint_pkg::OutIdxBits-1:0]       slot_index_o,
  output logic [btint_pkg::PageBits-1:0]         found_page_o,
  output logic [btint_pkg::OutIdxBits-1:0]       key_count_o,
  output logic                                   status_o
);
  import btint_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CELLS);
  localparam logic [IdxW:0] MaxCellsW = (IdxW+1)'(MAX_CELLS);

  // Control and node state.
  state_e              state_q, state_d;
  logic [IdxW-1:0]     count_q, count_d;
  logic [PageBits-1:0] right_q, right_d;

  // Captured transaction.
  mode_e               mode_q;
  logic [KEY_BITS-1:0] ckey_q;
  logic [PageBits-1:0] cpage_q;
  logic                rmost_q;
  logic [MAX_CELLS-1:0] hit_q;

  // Result registers.
  logic                valid_q;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic [PageBits-1:0] res_page_q, res_page_d;
  logic [IdxW-1:0]     res_cnt_q;
  logic                res_status_q, res_status_d;

  // Cell chain signals.
  logic [KEY_BITS-1:0] cell_key  [MAX_CELLS];
  logic [PageBits-1:0] cell_page [MAX_CELLS];
  logic [MAX_CELLS-1:0] cell_hit;
  logic [KEY_BITS-1:0] cmp_key;
  cell_ctrl_t          ctrl;
  logic [IdxW-1:0]     tgt_idx;
  logic [PageBits-1:0] new_page;

  logic                accept;
  mode_e               mode_in;
  logic [IdxW-1:0]     enc_idx;
  logic                full;
  logic [PageBits-1:0] stored_page;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q == ST_EXEC);
  assign mode_in = mode_e'(mode_i);

  // Insert searches for the new child's key, every other mode for the search key.
  assign cmp_key = (mode_in == MODE_INSERT) ? KEY_BITS'(child_key_i)
                                            : KEY_BITS'(search_key_i);

  for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic [PageBits-1:0] prev_page;
    if (g == 0) begin : g_first
      assign prev_key  = '0;
      assign prev_page = '0;
    end else begin : g_rest
      assign prev_key  = cell_key[g-1];
      assign prev_page = cell_page[g-1];
    end
    btint_cell #(
      .MAX_CELLS (MAX_CELLS),
      .KEY_BITS  (KEY_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .tgt_idx_i   (tgt_idx),
      .lo_idx_i    (enc_idx),
      .cnt_i       (count_q),
      .cmp_key_i   (cmp_key),
      .new_key_i   (ckey_q),
      .new_page_i  (new_page),
      .prev_key_i  (prev_key),
      .prev_page_i (prev_page),
      .key_o       (cell_key[g]),
      .page_o      (cell_page[g]),
      .hit_o       (cell_hit[g])
    );
  end

  // The first registered hit gives the lower bound; no hit means the count.
  always_comb begin
    enc_idx = count_q;
    for (int i = MAX_CELLS - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        enc_idx = IdxW'(i);
      end
    end
  end

  assign full        = ({1'b0, count_q} + 1'b1) >= MaxCellsW;
  assign new_page    = (mode_q == MODE_INSERT && rmost_q) ? right_q : cpage_q;
  assign stored_page = (enc_idx < count_q) ? cell_page[enc_idx] : right_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    right_d      = right_q;
    ctrl         = '0;
    tgt_idx      = enc_idx;
    res_idx_d    = enc_idx;
    res_page_d   = stored_page;
    res_status_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (mode_q)
          MODE_FIND: begin
          end
          MODE_INSERT: begin
            if (full) begin
              res_status_d = 1'b1;
            end else if (rmost_q) begin
              // Old right child moves into a new last cell.
              ctrl.page_we = 1'b1;
              tgt_idx      = count_q;
              right_d      = cpage_q;
              count_d      = count_q + 1'b1;
            end else begin
              ctrl.shift   = 1'b1;
              ctrl.key_we  = 1'b1;
              ctrl.page_we = 1'b1;
              count_d      = count_q + 1'b1;
              res_page_d   = cpage_q;
            end
          end
          MODE_UPDATE: begin
            if (enc_idx < count_q) begin
              ctrl.key_we = 1'b1;
            end else if (count_q != '0) begin
              // No match: the key slot just past the last cell is written.
              ctrl.key_we = 1'b1;
              tgt_idx     = count_q;
            end
          end
          MODE_INIT: begin
            count_d    = '0;
            right_d    = cpage_q;
            res_idx_d  = '0;
            res_page_d = cpage_q;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      right_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      right_q <= right_d;
      valid_q <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_in;
      ckey_q  <= KEY_BITS'(child_key_i);
      cpage_q <= child_page_i;
      rmost_q <= rightmost_i;
      hit_q   <= cell_hit;
    end
    if (state_q == ST_EXEC) begin
      res_idx_q    <= res_idx_d;
      res_page_q   <= res_page_d;
      res_cnt_q    <= count_d;
      res_status_q <= res_status_d;
    end
  end

  assign valid_o       = valid_q;
  assign slot_index_o  = OutIdxBits'(res_idx_q);
  assign found_page_o  = res_page_q;
  assign key_count_o   = OutIdxBits'(res_cnt_q);
  assign status_o      = res_status_q;

endmodule

`default_nettype wire

FILE: sv/btint_cell.sv
// ----------------------------------------------------------------------------
// btint_cell
// One slot of the node: holds a key and a child page, compares its key
// against the search key and shifts up from its lower neighbor on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module btint_cell #(
  parameter int unsigned MAX_CELLS = btint_pkg::DefMaxCells,
  parameter int unsigned KEY_BITS  = btint_pkg::DefKeyBits,
  parameter int unsigned INDEX     = 0
) (
  input  wire                                  clk_i,
  input  btint_pkg::cell_ctrl_t                ctrl_i,
  input  wire  [$clog2(MAX_CELLS)-1:0]         tgt_idx_i,
  input  wire  [$clog2(MAX_CELLS)-1:0]         lo_idx_i,
  input  wire  [$clog2(MAX_CELLS)-1:0]         cnt_i,
  input  wire  [KEY_BITS-1:0]                  cmp_key_i,
  input  wire  [KEY_BITS-1:0]                  new_key_i,
  input  wire  [btint_pkg::PageBits-1:0]       new_page_i,
  input  wire  [KEY_BITS-1:0]                  prev_key_i,
  input  wire  [btint_pkg::PageBits-1:0]       prev_page_i,
  output logic [KEY_BITS-1:0]                  key_o,
  output logic [btint_pkg::PageBits-1:0]       page_o,
  output logic                                 hit_o
);
  import btint_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CELLS);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PageBits-1:0] page_q, page_d;
  logic                is_tgt, in_shift;

  assign is_tgt   = (tgt_idx_i == MyIdx);
  assign in_shift = ctrl_i.shift && (MyIdx > lo_idx_i) && (MyIdx <= cnt_i);

  // A slot below the count qualifies when its key is not below the search key.
  assign hit_o = (MyIdx < cnt_i) && !(key_q < cmp_key_i);

  always_comb begin
    key_d  = key_q;
    page_d = page_q;
    if (in_shift) begin
      key_d  = prev_key_i;
      page_d = prev_page_i;
    end
    if (is_tgt && ctrl_i.key_we) begin
      key_d = new_key_i;
    end
    if (is_tgt && ctrl_i.page_we) begin
      page_d = new_page_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    page_q <= page_d;
  end

  assign key_o  = key_q;
  assign page_o = page_q;

endmodule

`default_nettype wire
